@@ sv/meshlet_local_index_remap_top_macros.svh @@
// Assertion macros for the meshlet local index remap block.
`ifndef MESHLET_LOCAL_INDEX_REMAP_TOP_MACROS_SVH
`define MESHLET_LOCAL_INDEX_REMAP_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MLIR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mlir assertion failed");

// Next-cycle implication, disabled during reset.
`define MLIR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mlir assertion failed");

`endif

@@ sv/mlir_pkg.sv @@
// Shared widths, constants and channel payload types for the index remap block.
package mlir_pkg;

   localparam int VTX_W     = 32;
   localparam int LOC_W     = 6;
   localparam int CFG_W     = 7;
   localparam int TRI_CNT_W = 8;
   localparam int PACK_W    = 22;
   localparam int OFS_W     = 32;
   localparam int PACK_LANE = 8;

   localparam logic [CFG_W-1:0] CFG_LIMIT_RESET = 7'd64;

   typedef struct packed {
      logic [VTX_W-1:0] vertex_index;
      logic             last_corner;
   } req_payload_type;

   typedef struct packed {
      logic [LOC_W-1:0]     local_index;
      logic                 new_vertex;
      logic [VTX_W-1:0]     appended_index;
      logic                 triangle_valid;
      logic [PACK_W-1:0]    packed_triangle;
      logic                 cluster_done;
      logic [CFG_W-1:0]     cluster_vertices;
      logic [TRI_CNT_W-1:0] cluster_triangles;
      logic [OFS_W-1:0]     vertex_base;
      logic [OFS_W-1:0]     triangle_base;
      logic                 overflow;
   } rsp_payload_type;

endpackage

@@ sv/mlir_if.sv @@
// Valid/ready channel interfaces for corner requests and remap responses.
interface mlir_req_if;
   import mlir_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface mlir_rsp_if;
   import mlir_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ sv/mlir_cam.sv @@
// Unique vertex table: flop array with a parallel compare against every filled entry.
module mlir_cam #(
   parameter int ENTRIES = 64
) (
   input  logic                            clock,
   input  logic [mlir_pkg::VTX_W-1:0]      lookup_key,
   input  logic [$clog2(ENTRIES+1)-1:0]    fill_count,
   input  logic                            write_en,
   input  logic [$clog2(ENTRIES)-1:0]      write_addr,
   input  logic [mlir_pkg::VTX_W-1:0]      write_data,
   output logic                            hit,
   output logic [$clog2(ENTRIES)-1:0]      hit_index
);
   import mlir_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES+1);

   logic [VTX_W-1:0]   entry_ff [ENTRIES];
   logic [ENTRIES-1:0] match;

   always_ff @(posedge clock) begin
      if (write_en) begin
         entry_ff[write_addr] <= write_data;
      end
   end

   // entries below the fill count hold unique keys, so at most one can match
   always_comb begin
      hit_index = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = (entry_ff[i] == lookup_key) && (CNT_W'(i) < fill_count);
         if (match[i]) begin
            hit_index = hit_index | IDX_W'(i);
         end
      end
   end

   assign hit = |match;

endmodule

@@ sv/meshlet_local_index_remap_top.sv @@
// Top level of the meshlet local index remap block.
//
// Corners enter on req_chan, one global vertex index per transfer, with
// last_corner set on the final corner of a cluster. Each corner gives exactly
// one response transfer on rsp_chan: its local index, whether it was appended
// to the unique table, and on every third corner, up to the triangle cap, the packed triangle. The
// response of the last corner also carries the cluster's vertex and triangle
// counts, the running list offsets before the cluster and the overflow flag.
// csr_write_en/csr_write_data set the usable table size; write it while idle.
//
// A corner transferred in sits in the input register, goes through the table
// compare and update into the response register, and transfers out from there.
// Throughput is one corner per cycle while the receiver takes responses, using a
// parallel compare over all table entries. When the receiver stalls, the
// response register holds and one more corner is taken into the input register
// before req_chan.ready drops. Synchronous reset clears the table fill count,
// cluster counters, running offsets and limit (back to 64); no clearing pass is
// needed, so the block is ready in the cycle after reset.
module meshlet_local_index_remap_top #(
   parameter int TABLE_ENTRIES         = 64,
   parameter int MAX_CLUSTER_TRIANGLES = 255
) (
   input  logic                        clock,
   input  logic                        reset,
   mlir_req_if.sink                    req_chan,
   mlir_rsp_if.source                  rsp_chan,
   input  logic                        csr_write_en,
   input  logic [mlir_pkg::CFG_W-1:0]  csr_write_data
);
   import mlir_pkg::*;

   `include "meshlet_local_index_remap_top_macros.svh"

   localparam int IDX_W   = $clog2(TABLE_ENTRIES);
   localparam int CNT_W   = $clog2(TABLE_ENTRIES+1);
   localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int TRI_CAP = (MAX_CLUSTER_TRIANGLES > 255) ? 255 : MAX_CLUSTER_TRIANGLES;

   // configuration
   logic [CFG_W-1:0] limit_ff;

   // input register
   logic             s1_valid_ff;
   req_payload_type  s1_payload_ff;
   logic             s1_advance;

   // response register
   logic             out_valid_ff;
   rsp_payload_type  out_payload_ff;
   rsp_payload_type  out_payload_in;

   // cluster state
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [1:0]           phase_ff, phase_in;
   logic [LOC_W-1:0]     held0_ff, held0_in;
   logic [LOC_W-1:0]     held1_ff, held1_in;
   logic [TRI_CNT_W-1:0] tri_count_ff, tri_count_in;
   logic                 overflow_ff, overflow_in;
   logic [OFS_W-1:0]     vtx_total_ff, vtx_total_in;
   logic [OFS_W-1:0]     tri_total_ff, tri_total_in;

   // lookup
   logic             hit;
   logic [IDX_W-1:0] hit_index;
   logic             room;
   logic             append;
   logic             miss_full;
   logic [IDX_W-1:0] local_idx;
   logic [LOC_W-1:0] local6;
   logic             tri_done;
   logic             tri_kept;

   // assertion terms
   logic             hit_kept;
   logic             rsp_overflow;

   assign s1_advance     = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_payload_ff;

   mlir_cam #(
      .ENTRIES (TABLE_ENTRIES)
   ) u_cam (
      .clock      (clock),
      .lookup_key (s1_payload_ff.vertex_index),
      .fill_count (count_ff),
      .write_en   (s1_advance && append),
      .write_addr (count_ff[IDX_W-1:0]),
      .write_data (s1_payload_ff.vertex_index),
      .hit        (hit),
      .hit_index  (hit_index)
   );

   always_comb begin
      room = (CMP_W'(count_ff) < CMP_W'(limit_ff)) &&
             (CMP_W'(count_ff) < CMP_W'(TABLE_ENTRIES));
      append    = !hit && room;
      miss_full = !hit && !room;
      if (hit) begin
         local_idx = hit_index;
      end else if (append) begin
         local_idx = count_ff[IDX_W-1:0];
      end else begin
         local_idx = '0;
      end
      local6   = LOC_W'(local_idx);
      tri_done = (phase_ff == 2'd2);
      tri_kept = tri_done && (tri_count_ff < TRI_CNT_W'(TRI_CAP));

      count_in     = count_ff + CNT_W'(append);
      tri_count_in = tri_count_ff + TRI_CNT_W'(tri_kept);
      overflow_in  = overflow_ff | miss_full;
      held0_in     = held0_ff;
      held1_in     = held1_ff;
      if (tri_done) begin
         phase_in = 2'd0;
      end else begin
         phase_in = phase_ff + 2'd1;
         if (phase_ff[0]) begin
            held1_in = local6;
         end else begin
            held0_in = local6;
         end
      end
      vtx_total_in = vtx_total_ff;
      tri_total_in = tri_total_ff;

      out_payload_in = '0;
      out_payload_in.local_index    = local6;
      out_payload_in.new_vertex     = append;
      out_payload_in.appended_index = append ? s1_payload_ff.vertex_index : '0;
      out_payload_in.triangle_valid = tri_kept;
      if (tri_kept) begin
         out_payload_in.packed_triangle = {local6, (PACK_LANE-LOC_W)'(0), held1_ff,
                                           (PACK_LANE-LOC_W)'(0), held0_ff};
      end

      if (s1_payload_ff.last_corner) begin
         out_payload_in.cluster_done      = 1'b1;
         out_payload_in.cluster_vertices  = CFG_W'(count_in);
         out_payload_in.cluster_triangles = tri_count_in;
         out_payload_in.vertex_base       = vtx_total_ff;
         out_payload_in.triangle_base     = tri_total_ff;
         out_payload_in.overflow          = overflow_in;
         vtx_total_in = vtx_total_ff + OFS_W'(count_in);
         tri_total_in = tri_total_ff + OFS_W'(tri_count_in);
         count_in     = '0;
         phase_in     = 2'd0;
         held0_in     = '0;
         held1_in     = '0;
         tri_count_in = '0;
         overflow_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= CFG_LIMIT_RESET;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
         phase_ff     <= 2'd0;
         held0_ff     <= '0;
         held1_ff     <= '0;
         tri_count_ff <= '0;
         overflow_ff  <= 1'b0;
         vtx_total_ff <= '0;
         tri_total_ff <= '0;
      end else begin
         if (csr_write_en) begin
            limit_ff <= csr_write_data;
         end
         if (req_chan.ready) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (s1_advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (s1_advance) begin
            count_ff     <= count_in;
            phase_ff     <= phase_in;
            held0_ff     <= held0_in;
            held1_ff     <= held1_in;
            tri_count_ff <= tri_count_in;
            overflow_ff  <= overflow_in;
            vtx_total_ff <= vtx_total_in;
            tri_total_ff <= tri_total_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         s1_payload_ff <= req_chan.payload;
      end
      if (s1_advance) begin
         out_payload_ff <= out_payload_in;
      end
   end

   assign hit_kept     = s1_advance && hit && !s1_payload_ff.last_corner;
   assign rsp_overflow = rsp_chan.valid && rsp_chan.payload.overflow;

   `MLIR_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, CMP_W'(count_ff) <= CMP_W'(TABLE_ENTRIES))
   `MLIR_ASSERT_NEXT(a_hit_no_append, clock, reset, hit_kept, count_ff == $past(count_ff))
   `MLIR_ASSERT_NOW(a_overflow_at_end, clock, reset, rsp_overflow, rsp_chan.payload.cluster_done)
   `MLIR_ASSERT_NOW(a_ready_when_empty, clock, reset, !out_valid_ff, req_chan.ready)

endmodule

@@ test/meshlet_local_index_remap_top_tb.sv @@
// Self-checking testbench for the meshlet local index remap block.
`timescale 1ns / 1ps

module meshlet_local_index_remap_top_tb;
   import mlir_pkg::*;

   localparam int CLK_PERIOD          = 20;
   localparam int RESET_CYCLES        = 10;
   localparam int TABLE_DEPTH         = 64;
   localparam int TRI_LIMIT           = 255;
   localparam int TRI_CAP             = (TRI_LIMIT > 255) ? 255 : TRI_LIMIT;
   localparam int DRAIN_CYCLES        = 6;
   localparam int HOLD_CYCLES         = 400;
   localparam int WATCHDOG_LIMIT      = 4000;
   localparam int PHASE_ITEMS         = 140;
   localparam int NUM_PHASES          = 7;
   localparam int CAP_CLUSTER_CORNERS = 775;
   localparam int MAX_REPORTS         = 10;

   typedef struct {
      int               limit_before;   // -1 keeps the current limit
      logic [VTX_W-1:0] vertex;
      logic             last;
      bit               typed;
      rsp_payload_type  rsp;
   } directed_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_write_en;
   logic [CFG_W-1:0]    csr_write_data;

   mlir_req_if req_chan ();
   mlir_rsp_if rsp_chan ();

   meshlet_local_index_remap_top #(
      .TABLE_ENTRIES         (TABLE_DEPTH),
      .MAX_CLUSTER_TRIANGLES (TRI_LIMIT)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Shadow of the block's cluster state
   logic [VTX_W-1:0]     uniq_table [TABLE_DEPTH];
   logic [CFG_W-1:0]     uniq_count     = '0;
   logic [1:0]           corner_phase   = '0;
   logic [LOC_W-1:0]     held_corner [2] = '{default: '0};
   logic [TRI_CNT_W-1:0] tri_in_cluster = '0;
   logic [OFS_W-1:0]     vertex_total   = '0;
   logic [OFS_W-1:0]     triangle_total = '0;
   bit                   overflow_seen  = 1'b0;
   logic [CFG_W-1:0]     vertex_limit   = CFG_LIMIT_RESET;

   rsp_payload_type  pending_remaps [$];
   directed_row_type directed_rows [$];
   int               mismatch_count  = 0;
   int               burst_left      = 0;
   int               holds_requested = 0;
   int               holds_served    = 0;
   int               idle_cycles     = 0;

   function automatic rsp_payload_type remap_corner(input req_payload_type c);
      rsp_payload_type r;
      logic [LOC_W-1:0] loc;
      bit               hit;
      int               usable;
      r      = '0;
      loc    = '0;
      hit    = 1'b0;
      usable = (vertex_limit > TABLE_DEPTH) ? TABLE_DEPTH : int'(vertex_limit);
      for (int i = 0; i < uniq_count && !hit; i++) begin
         if (uniq_table[i] == c.vertex_index) begin
            loc = LOC_W'(i);
            hit = 1'b1;
         end
      end
      if (!hit) begin
         if (uniq_count < usable) begin
            loc                    = uniq_count[LOC_W-1:0];
            uniq_table[uniq_count] = c.vertex_index;
            uniq_count++;
            r.new_vertex     = 1'b1;
            r.appended_index = c.vertex_index;
         end else begin
            // table full: nothing appended, corner maps to entry zero
            overflow_seen = 1'b1;
         end
      end
      r.local_index = loc;
      if (corner_phase == 2'd2) begin
         if (tri_in_cluster < TRI_CAP) begin
            r.triangle_valid  = 1'b1;
            r.packed_triangle = {loc, 2'b00, held_corner[1], 2'b00, held_corner[0]};
            tri_in_cluster++;
         end
         corner_phase = '0;
      end else begin
         held_corner[corner_phase[0]] = loc;
         corner_phase++;
      end
      if (c.last_corner) begin
         r.cluster_done      = 1'b1;
         r.cluster_vertices  = uniq_count;
         r.cluster_triangles = tri_in_cluster;
         r.vertex_base       = vertex_total;
         r.triangle_base     = triangle_total;
         r.overflow          = overflow_seen;
         vertex_total   += OFS_W'(uniq_count);
         triangle_total += OFS_W'(tri_in_cluster);
         uniq_count     = '0;
         corner_phase   = '0;
         held_corner    = '{default: '0};
         tri_in_cluster = '0;
         overflow_seen  = 1'b0;
      end
      return r;
   endfunction

   function automatic rsp_payload_type known_rsp(
      input logic [31:0] loc, input logic [31:0] newv, input logic [31:0] app,
      input logic [31:0] tv, input logic [31:0] pack, input logic [31:0] done,
      input logic [31:0] cv, input logic [31:0] ct, input logic [31:0] vo,
      input logic [31:0] to, input logic [31:0] ov);
      rsp_payload_type r;
      r.local_index       = loc[LOC_W-1:0];
      r.new_vertex        = newv[0];
      r.appended_index    = app;
      r.triangle_valid    = tv[0];
      r.packed_triangle   = pack[PACK_W-1:0];
      r.cluster_done      = done[0];
      r.cluster_vertices  = cv[CFG_W-1:0];
      r.cluster_triangles = ct[TRI_CNT_W-1:0];
      r.vertex_base       = vo;
      r.triangle_base     = to;
      r.overflow          = ov[0];
      return r;
   endfunction

   function automatic void add_row(input int lim, input logic [VTX_W-1:0] vtx,
                                   input logic last, input bit typed,
                                   input rsp_payload_type rsp);
      directed_row_type row;
      row.limit_before = lim;
      row.vertex       = vtx;
      row.last         = last;
      row.typed        = typed;
      row.rsp          = rsp;
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s expected %h got %h", $time, field, want, got);
      end
   endtask

   // Sender: random bursts separated by random gaps
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 16);
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic offer_corner(input req_payload_type c, input bit typed,
                               input rsp_payload_type typed_rsp);
      rsp_payload_type predicted;
      req_chan.valid   <= 1'b1;
      req_chan.payload <= c;
      do @(posedge clock); while (!req_chan.ready);
      predicted = remap_corner(c);
      pending_remaps.insert(pending_remaps.size(), typed ? typed_rsp : predicted);
   endtask

   task automatic set_limit(input logic [CFG_W-1:0] lim);
      req_chan.valid <= 1'b0;
      while (pending_remaps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= lim;
      @(posedge clock);
      csr_write_en <= 1'b0;
      vertex_limit = lim;
   endtask

   task automatic send_cluster(input int corners, input int pool_size);
      logic [VTX_W-1:0] pool [$];
      req_payload_type  c;
      for (int p = 0; p < pool_size; p++) begin
         case ($urandom_range(0, 5))
            0:       pool.insert(pool.size(), '0);
            1:       pool.insert(pool.size(), '1);
            2:       pool.insert(pool.size(), $urandom_range(0, 15));
            default: pool.insert(pool.size(), $urandom);
         endcase
      end
      for (int k = 0; k < corners; k++) begin
         // mostly reuse the cluster's pool, now and then a stray index
         c.vertex_index = ($urandom_range(0, 9) == 0) ? $urandom
                                                      : pool[$urandom_range(0, pool_size - 1)];
         c.last_corner  = (k == corners - 1);
         pace_sender();
         offer_corner(c, 1'b0, '0);
      end
   endtask

   // Receiver: stall patterns, plus long hold-offs on request
   initial begin : receiver
      int mode;
      int span;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (holds_served < holds_requested) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_served++;
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 120);
            for (int k = 0; k < span && holds_served == holds_requested; k++) begin
               case (mode)
                  0:       rsp_chan.ready <= 1'b1;
                  1:       rsp_chan.ready <= 1'($urandom_range(0, 1));
                  2:       rsp_chan.ready <= (k % 4 != 3);
                  default: rsp_chan.ready <= ($urandom_range(0, 9) == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin : response_check
      rsp_payload_type want;
      rsp_payload_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.payload;
         if (pending_remaps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: response transfer with nothing pending: %h", $time, got);
         end else begin
            want = pending_remaps.pop_front();
            check_field("local_index", 32'(want.local_index), 32'(got.local_index));
            check_field("new_vertex", 32'(want.new_vertex), 32'(got.new_vertex));
            check_field("appended_index", want.appended_index, got.appended_index);
            check_field("triangle_valid", 32'(want.triangle_valid),
                        32'(got.triangle_valid));
            check_field("packed_triangle", 32'(want.packed_triangle),
                        32'(got.packed_triangle));
            check_field("cluster_done", 32'(want.cluster_done), 32'(got.cluster_done));
            check_field("cluster_vertices", 32'(want.cluster_vertices),
                        32'(got.cluster_vertices));
            check_field("cluster_triangles", 32'(want.cluster_triangles),
                        32'(got.cluster_triangles));
            check_field("vertex_base", want.vertex_base, got.vertex_base);
            check_field("triangle_base", want.triangle_base, got.triangle_base);
            check_field("overflow", 32'(want.overflow), 32'(got.overflow));
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("meshlet_local_index_remap_top verification failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [CFG_W-1:0] lim;
      int               sent;
      int               len;
      req_payload_type  c;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      csr_write_en     <= 1'b0;
      csr_write_data   <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // limit 64 after reset: single-corner cluster, hits, a partial trailing triangle
      add_row(-1, 32'hFFFF_FFFF, 1'b1, 1'b1,
              known_rsp(0, 1, 32'hFFFF_FFFF, 0, 0, 1, 1, 0, 0, 0, 0));
      add_row(-1, 32'h0, 1'b0, 1'b1, known_rsp(0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      add_row(-1, 32'h0, 1'b0, 1'b1, known_rsp(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      add_row(-1, 32'h8000_0000, 1'b0, 1'b1,
              known_rsp(1, 1, 32'h8000_0000, 1, 32'h0001_0000, 0, 0, 0, 0, 0, 0));
      add_row(-1, 32'h0, 1'b1, 1'b1, known_rsp(0, 0, 0, 0, 0, 1, 2, 1, 1, 0, 0));
      // limit 1: table full after one vertex
      add_row(1, 32'h5, 1'b0, 1'b0, '0);
      add_row(-1, 32'h6, 1'b0, 1'b0, '0);
      add_row(-1, 32'h5, 1'b0, 1'b0, '0);
      add_row(-1, 32'h7, 1'b1, 1'b1, known_rsp(0, 0, 0, 0, 0, 1, 1, 1, 3, 1, 1));
      // limit 0: every corner overflows
      add_row(0, 32'hAAAA_AAAA, 1'b0, 1'b0, '0);
      add_row(-1, 32'h5555_5555, 1'b0, 1'b0, '0);
      add_row(-1, 32'h0, 1'b0, 1'b0, '0);
      add_row(-1, 32'h1, 1'b1, 1'b1, known_rsp(0, 0, 0, 0, 0, 1, 0, 1, 4, 2, 1));
      // limit above the table size is capped at the table size
      add_row(127, 32'd10, 1'b0, 1'b0, '0);
      add_row(-1, 32'd11, 1'b0, 1'b0, '0);
      add_row(-1, 32'd12, 1'b0, 1'b0, '0);
      add_row(-1, 32'd11, 1'b0, 1'b0, '0);
      add_row(-1, 32'd10, 1'b0, 1'b0, '0);
      add_row(-1, 32'd12, 1'b1, 1'b1,
              known_rsp(2, 0, 0, 1, 32'h0002_0001, 1, 3, 2, 4, 3, 0));

      foreach (directed_rows[n]) begin
         if (directed_rows[n].limit_before >= 0)
            set_limit(CFG_W'(directed_rows[n].limit_before));
         c.vertex_index = directed_rows[n].vertex;
         c.last_corner  = directed_rows[n].last;
         pace_sender();
         offer_corner(c, directed_rows[n].typed, directed_rows[n].rsp);
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0:       lim = CFG_LIMIT_RESET;
            1:       lim = CFG_W'($urandom_range(1, 64));
            2:       lim = '1;
            3:       lim = CFG_W'($urandom_range(65, 126));
            4:       lim = CFG_W'(2);
            5:       lim = CFG_W'($urandom_range(1, 16));
            default: lim = CFG_LIMIT_RESET;
         endcase
         set_limit(lim);
         sent = 0;
         if (ph == 0) begin
            // one cluster long enough to run into the triangle cap
            send_cluster(CAP_CLUSTER_CORNERS, 40);
            sent = CAP_CLUSTER_CORNERS;
         end
         if (ph == 2)
            holds_requested++;
         while (sent < PHASE_ITEMS) begin
            case ($urandom_range(0, 9))
               0:       len = $urandom_range(1, 2);
               1, 2:    len = 3 * $urandom_range(1, 30) + $urandom_range(1, 2);
               default: len = 3 * $urandom_range(1, 30);
            endcase
            send_cluster(len, $urandom_range(1, 80));
            sent += len;
         end
      end

      req_chan.valid <= 1'b0;
      while (pending_remaps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("meshlet_local_index_remap_top verification clean");
      else
         $display("meshlet_local_index_remap_top verification failed");
      $finish;
   end

endmodule
